// ----- rtl/core/azdr_pkg.sv -----
package azdr_pkg;

  localparam int unsigned SourcesDef = 16;
  localparam int unsigned SrcW       = 8;
  localparam int unsigned TimeW      = 64;
  localparam int unsigned RawW       = 64;
  localparam int unsigned DwellW     = 32;
  localparam int unsigned ThrW       = 8;
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned ResMax     = 3;
  localparam int unsigned ResCntW    = 2;

  localparam logic [DwellW-1:0] ActAssertRst = 32'd2000000;
  localparam logic [DwellW-1:0] ActClearRst  = 32'd20000000;
  localparam logic [DwellW-1:0] ZoneDwellRst = 32'd3000000;
  localparam logic [ThrW-1:0]   RestThrRst   = 8'd82;
  localparam logic [ThrW-1:0]   Zone2ThrRst  = 8'd134;
  localparam logic [SrcW-1:0]   DiagSrcRst   = 8'd255;

  localparam logic [CfgIdxW-1:0] REG_ACT_ASSERT = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_ACT_CLEAR  = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_ZONE_DWELL = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_REST_THR   = 8'd3;
  localparam logic [CfgIdxW-1:0] REG_ZONE2_THR  = 8'd4;
  localparam logic [CfgIdxW-1:0] REG_DIAG_SRC   = 8'd5;

  typedef enum logic [1:0] {
    OP_OTHER = 2'd0,
    OP_COUNT = 2'd1,
    OP_ACCUM = 2'd2,
    OP_HEART = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    FLAG_WORN   = 2'd0,
    FLAG_ACTIVE = 2'd1,
    FLAG_REST   = 2'd2,
    FLAG_ZONE2  = 2'd3
  } flag_e;

  typedef struct packed {
    logic [DwellW-1:0] act_assert;
    logic [DwellW-1:0] act_clear;
    logic [DwellW-1:0] zone_dwell;
    logic [ThrW-1:0]   rest_thr;
    logic [ThrW-1:0]   zone2_thr;
    logic [SrcW-1:0]   diag_src;
  } azdr_cfg_t;

  // per-source flag bits, kept in flops
  typedef struct packed {
    logic tracked;
    logic kind_count;
    logic raw_seen;
    logic act_test;
    logic act_flag;
    logic rest_test;
    logic rest_flag;
    logic zone2_test;
    logic zone2_flag;
  } azdr_bits_t;

  // per-source wide fields, kept in memory
  typedef struct packed {
    logic [RawW-1:0]  last_raw;
    logic [TimeW-1:0] act_edge;
    logic [TimeW-1:0] rest_edge;
    logic [TimeW-1:0] zone2_edge;
  } azdr_row_t;

  typedef struct packed {
    logic [SrcW-1:0]  src;
    flag_e            which;
    logic             occupied;
    logic [TimeW-1:0] time_us;
  } azdr_result_t;

  typedef struct packed {
    logic              en;
    azdr_bits_t        bits;
    azdr_row_t         row;
  } azdr_wr_t;

  typedef struct packed {
    logic             stored;
    logic             flag;
    logic             changed;
    logic [TimeW-1:0] edge_time;
  } dwell_t;

  function automatic dwell_t dwell(input logic test, input logic stored, input logic flag,
                                   input logic [TimeW-1:0] edge_time,
                                   input logic [TimeW-1:0] now,
                                   input logic [DwellW-1:0] set_time,
                                   input logic [DwellW-1:0] clr_time,
                                   input logic force_en);
    dwell_t           r;
    logic [TimeW-1:0] elapsed;
    r.stored    = test;
    r.edge_time = (test != stored) ? now : edge_time;
    r.flag      = flag;
    r.changed   = 1'b0;
    elapsed     = now - r.edge_time;
    if (force_en) begin
      if (flag != test) begin
        r.flag    = test;
        r.changed = 1'b1;
      end
    end else if (test && !flag && (elapsed >= {{(TimeW-DwellW){1'b0}}, set_time})) begin
      r.flag    = 1'b1;
      r.changed = 1'b1;
    end else if (!test && flag && (elapsed >= {{(TimeW-DwellW){1'b0}}, clr_time})) begin
      r.flag    = 1'b0;
      r.changed = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/azdr_rules.sv -----
module azdr_rules (
  input  azdr_pkg::azdr_cfg_t                       cfg_i,
  input  azdr_pkg::opcode_e                         op_i,
  input  logic                                      stale_i,
  input  logic signed [azdr_pkg::RawW-1:0]          raw_i,
  input  logic [azdr_pkg::TimeW-1:0]                now_i,
  input  logic [azdr_pkg::SrcW-1:0]                 src_i,
  input  azdr_pkg::azdr_bits_t                      bits_i,
  input  azdr_pkg::azdr_row_t                       row_i,
  output azdr_pkg::azdr_bits_t                      bits_o,
  output azdr_pkg::azdr_row_t                       row_o,
  output azdr_pkg::azdr_result_t                    res_o [azdr_pkg::ResMax],
  output logic [azdr_pkg::ResCntW-1:0]              res_cnt_o
);

  azdr_pkg::dwell_t       da;
  azdr_pkg::dwell_t       dr;
  azdr_pkg::dwell_t       dz;
  azdr_pkg::azdr_result_t cand [azdr_pkg::ResMax];
  logic [azdr_pkg::ResMax-1:0] cand_v;
  logic [azdr_pkg::RawW-1:0]   diff;
  logic                        act_test;
  logic                        worn;
  logic [azdr_pkg::ThrW-1:0]   hr;

  always_comb begin
    diff     = $unsigned(raw_i) - row_i.last_raw;
    act_test = !stale_i && (diff != '0) && !diff[azdr_pkg::RawW-1];
    hr       = raw_i[azdr_pkg::ThrW-1:0];
    worn     = bits_i.tracked && bits_i.act_flag && bits_i.kind_count;
    da = azdr_pkg::dwell(act_test, bits_i.act_test, bits_i.act_flag, row_i.act_edge, now_i,
                         cfg_i.act_assert, cfg_i.act_clear, stale_i);
    dr = azdr_pkg::dwell(worn && (hr < cfg_i.rest_thr), bits_i.rest_test, bits_i.rest_flag,
                         row_i.rest_edge, now_i, cfg_i.zone_dwell, cfg_i.zone_dwell, !worn);
    dz = azdr_pkg::dwell(worn && (hr >= cfg_i.zone2_thr), bits_i.zone2_test,
                         bits_i.zone2_flag, row_i.zone2_edge, now_i, cfg_i.zone_dwell,
                         cfg_i.zone_dwell, !worn);
  end

  always_comb begin
    bits_o  = bits_i;
    row_o   = row_i;
    cand_v  = '0;
    cand[0] = '{src: src_i, which: azdr_pkg::FLAG_REST, occupied: dr.flag, time_us: now_i};
    cand[1] = '{src: src_i, which: azdr_pkg::FLAG_ZONE2, occupied: dz.flag, time_us: now_i};
    cand[2] = '{src: src_i, which: azdr_pkg::FLAG_ZONE2, occupied: 1'b0, time_us: now_i};
    case (op_i)
      azdr_pkg::OP_COUNT, azdr_pkg::OP_ACCUM: begin
        bits_o.tracked    = 1'b1;
        bits_o.kind_count = (op_i == azdr_pkg::OP_COUNT);
        row_o.last_raw    = $unsigned(raw_i);
        if (!stale_i && !bits_i.raw_seen) begin
          bits_o.raw_seen = 1'b1;
        end else begin
          bits_o.act_test = da.stored;
          bits_o.act_flag = da.flag;
          row_o.act_edge  = da.edge_time;
          cand[0] = '{src: src_i,
                      which: (op_i == azdr_pkg::OP_COUNT) ? azdr_pkg::FLAG_WORN
                                                          : azdr_pkg::FLAG_ACTIVE,
                      occupied: da.flag, time_us: now_i};
          cand[1] = '{src: src_i, which: azdr_pkg::FLAG_REST, occupied: 1'b0,
                      time_us: now_i};
          cand_v[0] = da.changed;
          if (stale_i) begin
            bits_o.rest_flag  = 1'b0;
            bits_o.zone2_flag = 1'b0;
            cand_v[1]         = bits_i.rest_flag;
            cand_v[2]         = bits_i.zone2_flag;
          end
        end
      end
      azdr_pkg::OP_HEART: begin
        bits_o.rest_test  = dr.stored;
        bits_o.rest_flag  = dr.flag;
        row_o.rest_edge   = dr.edge_time;
        bits_o.zone2_test = dz.stored;
        bits_o.zone2_flag = dz.flag;
        row_o.zone2_edge  = dz.edge_time;
        cand_v[0]         = dr.changed;
        cand_v[1]         = dz.changed;
      end
      default: begin
      end
    endcase
  end

  // pack the valid candidates to the front, keeping order
  always_comb begin
    logic [azdr_pkg::ResCntW-1:0] n;
    n = '0;
    for (int i = 0; i < azdr_pkg::ResMax; i++) begin
      res_o[i] = cand[i];
    end
    for (int i = 0; i < azdr_pkg::ResMax; i++) begin
      if (cand_v[i]) begin
        res_o[n] = cand[i];
        n        = n + 1'b1;
      end
    end
    res_cnt_o = n;
  end

endmodule

// ----- rtl/core/azdr_state.sv -----
module azdr_state #(
  parameter int unsigned SOURCES = azdr_pkg::SourcesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [((SOURCES > 1) ? $clog2(SOURCES) : 1)-1:0] rd_idx_i,
  input  logic [((SOURCES > 1) ? $clog2(SOURCES) : 1)-1:0] cur_idx_i,
  input  logic [((SOURCES > 1) ? $clog2(SOURCES) : 1)-1:0] wr_idx_i,
  input  azdr_pkg::azdr_wr_t   wr_i,
  output azdr_pkg::azdr_bits_t bits_o,
  output azdr_pkg::azdr_row_t  row_o
);

  localparam int unsigned IdxW = (SOURCES > 1) ? $clog2(SOURCES) : 1;

  azdr_pkg::azdr_bits_t bits_q [SOURCES];
  azdr_pkg::azdr_row_t  mem_q [SOURCES];
  azdr_pkg::azdr_row_t  rd_data_q;
  azdr_pkg::azdr_row_t  fwd_q;
  logic                 fwd_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SOURCES; i++) begin
        bits_q[i] <= '0;
      end
      fwd_hit_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        bits_q[wr_idx_i] <= wr_i.bits;
      end
      if (rd_en_i) begin
        fwd_hit_q <= wr_i.en && (wr_idx_i == rd_idx_i);
      end
    end
  end

  // wide fields: every read of a row follows a write of the fields it uses
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_idx_i] <= wr_i.row;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_idx_i];
      fwd_q     <= wr_i.row;
    end
  end

  assign bits_o = bits_q[cur_idx_i[IdxW-1:0]];
  assign row_o  = fwd_hit_q ? fwd_q : rd_data_q;

endmodule

// ----- rtl/core/azdr_out_buf.sv -----
module azdr_out_buf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  azdr_pkg::azdr_result_t        res_i [azdr_pkg::ResMax],
  input  logic [azdr_pkg::ResCntW-1:0]  cnt_i,
  output logic                          can_load_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output azdr_pkg::azdr_result_t        res_o,
  output logic                          last_o
);

  azdr_pkg::azdr_result_t       ent_q [azdr_pkg::ResMax];
  logic [azdr_pkg::ResCntW-1:0] cnt_q, cnt_d;
  logic [azdr_pkg::ResCntW-1:0] head_q, head_d;
  logic                         pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign can_load_o  = (cnt_q == '0) || ((cnt_q == 2'd1) && out_ready_i);
  assign last_o      = (cnt_q == 2'd1);
  assign res_o       = ent_q[head_q];

  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    if (load_i) begin
      cnt_d  = cnt_i;
      head_d = '0;
    end else if (pop) begin
      cnt_d  = cnt_q - 1'b1;
      head_d = head_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      head_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= res_i;
    end
  end

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o)
    else $error("result buffer loaded while busy");
  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, head_q} + {1'b0, cnt_q}) <= 3'(azdr_pkg::ResMax))
    else $error("result window past buffer end");
  a_drain_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (cnt_q > 2'd1) && !load_i) |=> out_valid_o)
    else $error("pending result dropped");
`endif

endmodule

// ----- rtl/core/activity_zone_dwell_rules_core.sv -----
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_ready_o  | source, opcode, derived, stale, raw_value, time_us
// out     | output    | out_valid_o / out_ready_i| out_source, which_flag, occupied, out_time_us, last
// cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A request passes through the input register (row memory read), then the rules logic into
// the result buffer. One request per cycle while the buffer drains in time; a request with
// several results holds the buffer until all of them have drained, so the next request with
// results waits in the input register meanwhile. A request with no result leaves the input
// register without waiting for the buffer.
// Reset clears all per-source flags at once; no clearing pass. cfg is always ready.
module activity_zone_dwell_rules_core #(
  parameter int unsigned SOURCES = azdr_pkg::SourcesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [azdr_pkg::SrcW-1:0]         source_i,
  input  logic [1:0]                        opcode_i,
  input  logic                              derived_i,
  input  logic                              stale_i,
  input  logic signed [azdr_pkg::RawW-1:0]  raw_value_i,
  input  logic [azdr_pkg::TimeW-1:0]        time_us_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [azdr_pkg::SrcW-1:0]         out_source_o,
  output logic [1:0]                        which_flag_o,
  output logic                              occupied_o,
  output logic [azdr_pkg::TimeW-1:0]        out_time_us_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [azdr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [azdr_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned IdxW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam logic [azdr_pkg::SrcW:0] SrcLimit = (azdr_pkg::SrcW + 1)'(SOURCES);

  azdr_pkg::azdr_cfg_t              cfg_q;
  logic                             s1_valid_q, s1_valid_d;
  logic                             ign_q;
  azdr_pkg::opcode_e                op_q;
  logic                             stale_q;
  logic signed [azdr_pkg::RawW-1:0] raw_q;
  logic [azdr_pkg::TimeW-1:0]       time_q;
  logic [azdr_pkg::SrcW-1:0]        src_q;
  logic [IdxW-1:0]                  idx_q;

  logic                             accept;
  logic                             adv;
  logic                             ign_in;
  logic                             can_load;
  logic [azdr_pkg::ResCntW-1:0]     res_cnt;
  logic [azdr_pkg::ResCntW-1:0]     eff_cnt;
  azdr_pkg::azdr_bits_t             bits_rd;
  azdr_pkg::azdr_row_t              row_rd;
  azdr_pkg::azdr_bits_t             wr_bits;
  azdr_pkg::azdr_row_t              wr_row;
  azdr_pkg::azdr_wr_t               wr;
  azdr_pkg::azdr_result_t           res [azdr_pkg::ResMax];
  azdr_pkg::azdr_result_t           res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.act_assert <= azdr_pkg::ActAssertRst;
      cfg_q.act_clear  <= azdr_pkg::ActClearRst;
      cfg_q.zone_dwell <= azdr_pkg::ZoneDwellRst;
      cfg_q.rest_thr   <= azdr_pkg::RestThrRst;
      cfg_q.zone2_thr  <= azdr_pkg::Zone2ThrRst;
      cfg_q.diag_src   <= azdr_pkg::DiagSrcRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        azdr_pkg::REG_ACT_ASSERT: cfg_q.act_assert <= cfg_data_i;
        azdr_pkg::REG_ACT_CLEAR:  cfg_q.act_clear  <= cfg_data_i;
        azdr_pkg::REG_ZONE_DWELL: cfg_q.zone_dwell <= cfg_data_i;
        azdr_pkg::REG_REST_THR:   cfg_q.rest_thr   <= cfg_data_i[azdr_pkg::ThrW-1:0];
        azdr_pkg::REG_ZONE2_THR:  cfg_q.zone2_thr  <= cfg_data_i[azdr_pkg::ThrW-1:0];
        azdr_pkg::REG_DIAG_SRC:   cfg_q.diag_src   <= cfg_data_i[azdr_pkg::SrcW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign ign_in = derived_i || (source_i == cfg_q.diag_src) ||
                  ({1'b0, source_i} >= SrcLimit) ||
                  (opcode_i == azdr_pkg::OP_OTHER);

  assign accept     = in_valid_i && in_ready_o;
  assign eff_cnt    = ign_q ? '0 : res_cnt;
  assign adv        = s1_valid_q && ((eff_cnt == '0) || can_load);
  assign in_ready_o = !s1_valid_q || adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ign_q   <= ign_in;
      op_q    <= azdr_pkg::opcode_e'(opcode_i);
      stale_q <= stale_i;
      raw_q   <= raw_value_i;
      time_q  <= time_us_i;
      src_q   <= source_i;
      idx_q   <= source_i[IdxW-1:0];
    end
  end

  azdr_state #(
    .SOURCES (SOURCES)
  ) u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && !ign_in),
    .rd_idx_i  (source_i[IdxW-1:0]),
    .cur_idx_i (idx_q),
    .wr_idx_i  (idx_q),
    .wr_i      (wr),
    .bits_o    (bits_rd),
    .row_o     (row_rd)
  );

  assign wr = '{en: adv && !ign_q, bits: wr_bits, row: wr_row};

  azdr_rules u_rules (
    .cfg_i     (cfg_q),
    .op_i      (op_q),
    .stale_i   (stale_q),
    .raw_i     (raw_q),
    .now_i     (time_q),
    .src_i     (src_q),
    .bits_i    (bits_rd),
    .row_i     (row_rd),
    .bits_o    (wr_bits),
    .row_o     (wr_row),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  azdr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv && (eff_cnt != '0)),
    .res_i       (res),
    .cnt_i       (eff_cnt),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out),
    .last_o      (last_o)
  );

  assign out_source_o  = res_out.src;
  assign which_flag_o  = res_out.which;
  assign occupied_o    = res_out.occupied;
  assign out_time_us_o = res_out.time_us;

`ifndef ASSERT_OFF
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> (s1_valid_q && $stable(src_q) && $stable(time_q)))
    else $error("stalled request lost");
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted request not held");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import azdr_pkg::*;

  localparam int unsigned NSRC      = SourcesDef;
  localparam int          IDLE_MAX  = 2000;
  localparam int          SETTLE    = 8;
  localparam int          HOLD_LEN  = 250;

  typedef struct packed {
    logic [SrcW-1:0]  src;
    opcode_e          op;
    logic             derived;
    logic             stale;
    logic [RawW-1:0]  raw;
    logic [TimeW-1:0] stamp;
  } sample_t;

  typedef struct packed {
    logic [SrcW-1:0]  src;
    flag_e            which;
    logic             occupied;
    logic [TimeW-1:0] stamp;
    logic             last;
  } flag_change_t;

  typedef struct packed {
    logic             test;
    logic             flag;
    logic [TimeW-1:0] since;
  } dwell_state_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [SrcW-1:0]     source_i    = '0;
  logic [1:0]          opcode_i    = '0;
  logic                derived_i   = 1'b0;
  logic                stale_i     = 1'b0;
  logic [RawW-1:0]     raw_value_i = '0;
  logic [TimeW-1:0]    time_us_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [SrcW-1:0]     out_source_o;
  logic [1:0]          which_flag_o;
  logic                occupied_o;
  logic [TimeW-1:0]    out_time_us_o;
  logic                last_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  activity_zone_dwell_rules_core #(
    .SOURCES(NSRC)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .source_i     (source_i),
    .opcode_i     (opcode_i),
    .derived_i    (derived_i),
    .stale_i      (stale_i),
    .raw_value_i  (raw_value_i),
    .time_us_i    (time_us_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_source_o (out_source_o),
    .which_flag_o (which_flag_o),
    .occupied_o   (occupied_o),
    .out_time_us_o(out_time_us_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // configuration shadow
  logic [DwellW-1:0] act_assert_cfg = ActAssertRst;
  logic [DwellW-1:0] act_clear_cfg  = ActClearRst;
  logic [DwellW-1:0] zone_dwell_cfg = ZoneDwellRst;
  logic [ThrW-1:0]   rest_thr_cfg   = RestThrRst;
  logic [ThrW-1:0]   zone2_thr_cfg  = Zone2ThrRst;
  logic [SrcW-1:0]   diag_src_cfg   = DiagSrcRst;

  // per-source state
  logic         tracked_q    [NSRC] = '{default: 1'b0};
  logic         kind_count_q [NSRC] = '{default: 1'b0};
  logic         raw_seen_q   [NSRC] = '{default: 1'b0};
  logic [63:0]  last_raw_q   [NSRC] = '{default: 64'd0};
  dwell_state_t act_st       [NSRC] = '{default: '0};
  dwell_state_t rest_st      [NSRC] = '{default: '0};
  dwell_state_t zone2_st     [NSRC] = '{default: '0};

  // stimulus generator history
  logic [63:0]  gen_time [NSRC] = '{default: 64'd0};
  logic [63:0]  gen_raw  [NSRC] = '{default: 64'd0};

  sample_t      sample_q[$];
  flag_change_t flag_changes_q[$];
  sample_t      cur_sample = '0;

  int queued_cnt   = 0;
  int accepted_cnt = 0;
  int seen_cnt     = 0;
  int failures     = 0;
  int in_gap       = 0;
  int out_stall    = 0;
  int hold_left    = 0;
  int idle_cycles  = 0;
  bit held         = 1'b0;
  bit quiet        = 1'b0;

  function automatic logic debounce(inout dwell_state_t st, input logic test,
                                    input logic [63:0] now, input logic [31:0] set_t,
                                    input logic [31:0] clr_t, input logic forced);
    logic [63:0] elapsed;
    if (test != st.test) begin
      st.test  = test;
      st.since = now;
    end
    elapsed = now - st.since;
    if (forced) begin
      if (st.flag != test) begin
        st.flag = test;
        return 1'b1;
      end
      return 1'b0;
    end
    if (test && !st.flag && elapsed >= {32'd0, set_t}) begin
      st.flag = 1'b1;
      return 1'b1;
    end
    if (!test && st.flag && elapsed >= {32'd0, clr_t}) begin
      st.flag = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_change(input logic [7:0] src, input flag_e which,
                                      input logic occ, input logic [63:0] now);
    flag_changes_q.push_back('{src: src, which: which, occupied: occ, stamp: now, last: 1'b0});
  endfunction

  // update source state for one accepted request, queue the flag changes it causes
  function automatic void track_sample(input sample_t s);
    int          start_cnt;
    int unsigned idx;
    logic        test;
    logic        worn;
    logic [63:0] delta;
    logic [7:0]  hr;
    start_cnt = flag_changes_q.size();
    if (s.derived || s.src == diag_src_cfg || s.src >= NSRC || s.op == OP_OTHER) return;
    idx = s.src;
    if (s.op == OP_COUNT || s.op == OP_ACCUM) begin
      tracked_q[idx]    = 1'b1;
      kind_count_q[idx] = (s.op == OP_COUNT);
      if (s.stale) begin
        test = 1'b0;
      end else if (raw_seen_q[idx]) begin
        delta = s.raw - last_raw_q[idx];
        test  = (delta != 64'd0) && !delta[63];
      end else begin
        raw_seen_q[idx] = 1'b1;
        last_raw_q[idx] = s.raw;
        return;
      end
      last_raw_q[idx] = s.raw;
      if (debounce(act_st[idx], test, s.stamp, act_assert_cfg, act_clear_cfg, s.stale))
        push_change(s.src, (s.op == OP_COUNT) ? FLAG_WORN : FLAG_ACTIVE, act_st[idx].flag,
                    s.stamp);
      if (s.stale) begin
        if (rest_st[idx].flag) begin
          rest_st[idx].flag = 1'b0;
          push_change(s.src, FLAG_REST, 1'b0, s.stamp);
        end
        if (zone2_st[idx].flag) begin
          zone2_st[idx].flag = 1'b0;
          push_change(s.src, FLAG_ZONE2, 1'b0, s.stamp);
        end
      end
    end else begin
      hr   = s.raw[7:0];
      worn = tracked_q[idx] && act_st[idx].flag && kind_count_q[idx];
      if (debounce(rest_st[idx], worn && (hr < rest_thr_cfg), s.stamp, zone_dwell_cfg,
                   zone_dwell_cfg, !worn))
        push_change(s.src, FLAG_REST, rest_st[idx].flag, s.stamp);
      if (debounce(zone2_st[idx], worn && (hr >= zone2_thr_cfg), s.stamp, zone_dwell_cfg,
                   zone_dwell_cfg, !worn))
        push_change(s.src, FLAG_ZONE2, zone2_st[idx].flag, s.stamp);
    end
    if (flag_changes_q.size() > start_cnt)
      flag_changes_q[flag_changes_q.size()-1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  // sample driver
  always @(posedge clk_i) begin
    logic offer;
    if (rst_ni) begin
      offer = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        track_sample(cur_sample);
        accepted_cnt++;
        offer = 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 10);
      end
      if (!offer) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (sample_q.size() > 0) begin
          cur_sample = sample_q.pop_front();
          offer      = 1'b1;
        end
      end
      in_valid_i  <= offer;
      source_i    <= cur_sample.src;
      opcode_i    <= cur_sample.op;
      derived_i   <= cur_sample.derived;
      stale_i     <= cur_sample.stale;
      raw_value_i <= cur_sample.raw;
      time_us_i   <= cur_sample.stamp;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    flag_change_t want;
    logic         ready_nxt;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen_cnt++;
        if (flag_changes_q.size() == 0) begin
          $error("unexpected result: source %0d flag %0d occupied %0d",
                 out_source_o, which_flag_o, occupied_o);
          failures++;
        end else begin
          want = flag_changes_q.pop_front();
          check_field("out_source", 64'(want.src), 64'(out_source_o));
          check_field("which_flag", 64'(want.which), 64'(which_flag_o));
          check_field("occupied", 64'(want.occupied), 64'(occupied_o));
          check_field("out_time_us", want.stamp, out_time_us_o);
          check_field("last", 64'(want.last), 64'(last_o));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_nxt = 1'b0;
      end else if (!held && seen_cnt >= 10 && sample_q.size() > 0) begin
        // long back-pressure so the pipeline fills and stalls requests
        held      = 1'b1;
        hold_left = HOLD_LEN;
        ready_nxt = 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        ready_nxt = 1'b0;
      end else begin
        ready_nxt = 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) out_stall = $urandom_range(1, 10);
      end
      out_ready_i <= ready_nxt;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_MAX) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_ACT_ASSERT: act_assert_cfg = data;
      REG_ACT_CLEAR:  act_clear_cfg  = data;
      REG_ZONE_DWELL: zone_dwell_cfg = data;
      REG_REST_THR:   rest_thr_cfg   = data[ThrW-1:0];
      REG_ZONE2_THR:  zone2_thr_cfg  = data[ThrW-1:0];
      REG_DIAG_SRC:   diag_src_cfg   = data[SrcW-1:0];
      default: ;
    endcase
  endtask

  function automatic void queue_sample(input logic [7:0] src, input opcode_e op,
                                       input logic derived, input logic stale,
                                       input logic [63:0] raw, input logic [63:0] stamp);
    sample_q.push_back('{src: src, op: op, derived: derived, stale: stale, raw: raw,
                         stamp: stamp});
    queued_cnt++;
  endfunction

  // mostly well-formed per-source streams, with noise mixed in
  task automatic queue_random(input int count);
    logic [7:0]  src;
    logic [3:0]  slot;
    opcode_e     op;
    logic [63:0] raw;
    logic [63:0] step;
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) src = 8'($urandom_range(0, 3));
      else if (pick < 94) src = 8'($urandom_range(0, NSRC-1));
      else src = 8'($urandom_range(0, 255));
      slot = src[3:0];
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_COUNT;
      else if (pick < 55) op = OP_ACCUM;
      else if (pick < 95) op = OP_HEART;
      else op = OP_OTHER;
      case ($urandom_range(0, 5))
        0: step = 64'($urandom_range(0, 200));
        1: step = 64'($urandom_range(0, 3000));
        2: step = 64'($urandom_range(0, 60000));
        3: step = 64'($urandom_range(1000000, 4000000));
        4: step = 64'($urandom_range(0, 25000000));
        default: step = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : 64'd0;
      endcase
      gen_time[slot] += step;
      if (op == OP_HEART) begin
        raw = {$urandom, $urandom};
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) raw = gen_raw[slot] + 64'($urandom_range(1, 5));
        else if (pick < 8) raw = gen_raw[slot];
        else if (pick < 9) raw = gen_raw[slot] - 64'($urandom_range(1, 1000));
        else raw = {$urandom, $urandom};
        gen_raw[slot] = raw;
      end
      queue_sample(src, op, $urandom_range(0, 19) == 0, $urandom_range(0, 11) == 0, raw,
                   gen_time[slot]);
    end
  endtask

  task automatic drain();
    while (accepted_cnt != queued_cnt || flag_changes_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration: ignored requests, wrapping deltas and timestamps
    queue_sample(8'd0,   OP_COUNT, 1'b1, 1'b0, 64'd5, 64'd100);
    queue_sample(8'd255, OP_COUNT, 1'b0, 1'b0, 64'd5, 64'd100);
    queue_sample(8'd16,  OP_HEART, 1'b0, 1'b0, 64'd60, 64'd100);
    queue_sample(8'd3,   OP_OTHER, 1'b0, 1'b0, 64'd1, 64'd100);
    queue_sample(8'd0,   OP_COUNT, 1'b0, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
    queue_sample(8'd0,   OP_COUNT, 1'b0, 1'b0, 64'h8000_0000_0000_0000, 64'd1000);
    queue_sample(8'd0,   OP_COUNT, 1'b0, 1'b0, 64'h8000_0000_0000_0005, 64'd2001000);
    queue_sample(8'd0,   OP_HEART, 1'b0, 1'b0, 64'd60, 64'd2002000);
    queue_sample(8'd0,   OP_HEART, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FF3C, 64'd5002000);
    queue_sample(8'd0,   OP_HEART, 1'b0, 1'b1, 64'd200, 64'd5003000);
    queue_sample(8'd0,   OP_HEART, 1'b0, 1'b0, 64'd255, 64'd8003000);
    queue_sample(8'd0,   OP_COUNT, 1'b0, 1'b0, 64'h8000_0000_0000_0005, 64'd8004000);
    queue_sample(8'd0,   OP_COUNT, 1'b0, 1'b1, 64'd0, 64'd8005000);
    queue_sample(8'd0,   OP_HEART, 1'b0, 1'b0, 64'd100, 64'd8006000);
    queue_sample(8'd1,   OP_ACCUM, 1'b0, 1'b1, 64'd77, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_sample(8'd1,   OP_ACCUM, 1'b0, 1'b0, 64'd10, 64'd0);
    queue_sample(8'd1,   OP_ACCUM, 1'b0, 1'b0, 64'd9, 64'd5);
    queue_sample(8'd1,   OP_ACCUM, 1'b0, 1'b0, 64'd20, 64'hFFFF_FFFF_FFFF_FFF0);
    queue_sample(8'd1,   OP_ACCUM, 1'b0, 1'b0, 64'd30, 64'd2000000);
    queue_sample(8'd15,  OP_COUNT, 1'b0, 1'b0, 64'h8000_0000_0000_0000, 64'd0);
    drain();

    // zero dwell, overlapping thresholds, upper data bits must be dropped
    write_reg(REG_ACT_ASSERT, 32'd0);
    write_reg(REG_ACT_CLEAR,  32'd0);
    write_reg(REG_ZONE_DWELL, 32'd0);
    write_reg(REG_REST_THR,   32'hFFFF_FFC8);
    write_reg(REG_ZONE2_THR,  32'h1234_5664);
    write_reg(REG_DIAG_SRC,   32'hFFFF_FF05);
    write_reg(8'd6,   32'hDEAD_BEEF);
    write_reg(8'd255, 32'hFFFF_FFFF);
    queue_sample(8'd5, OP_COUNT, 1'b0, 1'b0, 64'd1, 64'd10);
    queue_sample(8'd2, OP_COUNT, 1'b0, 1'b0, 64'd100, 64'd10);
    queue_sample(8'd2, OP_COUNT, 1'b0, 1'b0, 64'd101, 64'd20);
    queue_sample(8'd2, OP_HEART, 1'b0, 1'b0, 64'd150, 64'd30);
    queue_sample(8'd2, OP_COUNT, 1'b0, 1'b1, 64'd0, 64'd40);
    queue_sample(8'd2, OP_HEART, 1'b0, 1'b0, 64'd150, 64'd50);
    queue_sample(8'd2, OP_COUNT, 1'b0, 1'b0, 64'd1, 64'd60);
    queue_sample(8'd2, OP_COUNT, 1'b0, 1'b0, 64'd1, 64'd70);
    queue_random(30);
    drain();

    write_reg(REG_ACT_ASSERT, 32'hFFFF_FFFF);
    write_reg(REG_ACT_CLEAR,  32'd1500);
    write_reg(REG_ZONE_DWELL, 32'd0);
    write_reg(REG_REST_THR,   32'd255);
    write_reg(REG_ZONE2_THR,  32'd0);
    write_reg(REG_DIAG_SRC,   32'd0);
    queue_random(30);
    drain();

    write_reg(REG_ACT_ASSERT, 32'd1500);
    write_reg(REG_ACT_CLEAR,  32'hFFFF_FFFF);
    write_reg(REG_ZONE_DWELL, 32'd2500);
    write_reg(REG_REST_THR,   32'd90);
    write_reg(REG_ZONE2_THR,  32'd140);
    write_reg(REG_DIAG_SRC,   32'd255);
    queue_random(30);
    drain();

    quiet = 1'b1;
    queue_random(40);
    drain();

    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
